// ----- rtl/core/strided_nd_address_walker_macros.svh -----
// Assertion macros shared by the strided address walker RTL.
`ifndef STRIDED_ND_ADDRESS_WALKER_MACROS_SVH
`define STRIDED_ND_ADDRESS_WALKER_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define SWALK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("walker assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define SWALK_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("walker assertion failed");
`else
`define SWALK_ASSERT(lbl, prop)
`define SWALK_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

// ----- rtl/core/swalk_pkg.sv -----
// Types, widths and helper functions of the strided address walker.
`timescale 1ns / 1ps
package swalk_pkg;
    localparam int SIZE_W     = 9;
    localparam int STEP_W     = 24;
    localparam int IDX_W      = 8;
    localparam int SRC_W      = 34;
    localparam int DST_W      = 32;
    localparam int PROD_W     = STEP_W + IDX_W;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_EXTENT = 256;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic             last;
        logic [DST_W-1:0] dst;
    } t_walk_ctl;

    // Highest legal index of a dimension; a zero size acts as one, a size
    // above the maximum extent acts as the maximum extent.
    function automatic t_idx extent_limit(input logic [SIZE_W-1:0] size);
        t_idx lim;
        if (size == '0) begin
            lim = '0;
        end else if (size > SIZE_W'(MAX_EXTENT)) begin
            lim = IDX_W'(MAX_EXTENT - 1);
        end else begin
            lim = IDX_W'(size - SIZE_W'(1));
        end
        return lim;
    endfunction
endpackage

// ----- rtl/core/swalk_cfg.sv -----
// Configuration register file: per-dimension sizes and source strides.
`timescale 1ns / 1ps
module swalk_cfg #(
    parameter int NUM_DIMS  = 4,
    parameter int CFG_IDX_W = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we,
    input  logic [CFG_IDX_W-1:0]                   i_index,
    input  logic [swalk_pkg::CFG_DATA_W-1:0]       i_data,
    output logic [NUM_DIMS*swalk_pkg::SIZE_W-1:0]  o_size,
    output logic [NUM_DIMS*swalk_pkg::STEP_W-1:0]  o_step
);
    import swalk_pkg::*;

    localparam int SIZE_BASE = 0;
    localparam int STEP_BASE = NUM_DIMS;

    logic [SIZE_W-1:0] r_size [NUM_DIMS];
    logic [STEP_W-1:0] r_step [NUM_DIMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_size[d] <= SIZE_W'(1);
                r_step[d] <= (d == NUM_DIMS - 1) ? STEP_W'(1) : '0;
            end
        end else if (i_we) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                if (i_index == CFG_IDX_W'(SIZE_BASE + d)) begin
                    r_size[d] <= i_data[SIZE_W-1:0];
                end
                if (i_index == CFG_IDX_W'(STEP_BASE + d)) begin
                    r_step[d] <= i_data[STEP_W-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            o_size[d*SIZE_W +: SIZE_W] = r_size[d];
            o_step[d*STEP_W +: STEP_W] = r_step[d];
        end
    end
endmodule

// ----- rtl/core/swalk_index.sv -----
// Odometer index state: clamps, advances with carry and counts elements.
`timescale 1ns / 1ps
`include "strided_nd_address_walker_macros.svh"
module swalk_index #(
    parameter int NUM_DIMS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic                                   i_restart,
    input  logic [NUM_DIMS*swalk_pkg::SIZE_W-1:0]  i_size,
    output logic [NUM_DIMS*swalk_pkg::IDX_W-1:0]   o_idx,
    output swalk_pkg::t_walk_ctl                   o_ctl
);
    import swalk_pkg::*;

    t_idx              r_idx [NUM_DIMS];
    t_idx              n_idx [NUM_DIMS];
    logic [DST_W-1:0]  r_cnt;
    logic [DST_W-1:0]  n_cnt;
    t_idx              clamped [NUM_DIMS];
    logic [NUM_DIMS-1:0] at_end;
    logic [NUM_DIMS-1:0] bump;
    logic              last;
    logic [DST_W-1:0]  base_cnt;

    // The innermost dimension always takes the increment; each dimension that
    // sits at its limit passes the carry outward. A carry out of the outermost
    // dimension ends the walk.
    always_comb begin
        t_idx base;
        t_idx lim;
        logic carry;
        carry = 1'b1;
        for (int d = NUM_DIMS - 1; d >= 0; d--) begin
            base       = i_restart ? '0 : r_idx[d];
            lim        = extent_limit(i_size[d*SIZE_W +: SIZE_W]);
            clamped[d] = (base > lim) ? lim : base;
            at_end[d]  = (clamped[d] == lim);
            bump[d]    = carry;
            carry      = carry & at_end[d];
        end
        last     = carry;
        base_cnt = i_restart ? '0 : r_cnt;
        n_cnt    = last ? '0 : base_cnt + DST_W'(1);
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (last) begin
                n_idx[d] = '0;
            end else if (bump[d]) begin
                n_idx[d] = at_end[d] ? '0 : clamped[d] + IDX_W'(1);
            end else begin
                n_idx[d] = clamped[d];
            end
            o_idx[d*IDX_W +: IDX_W] = clamped[d];
        end
        o_ctl.last = last;
        o_ctl.dst  = base_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_idx[d] <= '0;
            end
            r_cnt <= '0;
        end else if (i_accept) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_idx[d] <= n_idx[d];
            end
            r_cnt <= n_cnt;
        end
    end

    `SWALK_ASSERT_NEXT(a_wrap_clears, i_accept && o_ctl.last, r_cnt == '0 && r_idx[0] == '0)
    `SWALK_ASSERT_NEXT(a_count_steps, i_accept && !o_ctl.last, r_cnt == $past(o_ctl.dst) + DST_W'(1))
    `SWALK_ASSERT_NEXT(a_idle_holds, !i_accept, $stable(r_cnt) && $stable(r_idx[NUM_DIMS-1]))
endmodule

// ----- rtl/core/swalk_offset.sv -----
// Three-stage offset pipeline: index capture, stride products, sum and output.
`timescale 1ns / 1ps
`include "strided_nd_address_walker_macros.svh"
module swalk_offset #(
    parameter int NUM_DIMS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [NUM_DIMS*swalk_pkg::IDX_W-1:0]   i_idx,
    input  swalk_pkg::t_walk_ctl                   i_ctl,
    input  logic [NUM_DIMS*swalk_pkg::STEP_W-1:0]  i_step,
    output logic                                   o_valid,
    input  logic                                   i_m_ready,
    output logic [swalk_pkg::SRC_W-1:0]            o_src,
    output swalk_pkg::t_walk_ctl                   o_ctl
);
    import swalk_pkg::*;

    logic                        r_v1;
    logic [NUM_DIMS*IDX_W-1:0]   r_idx1;
    t_walk_ctl                   r_ctl1;
    logic                        r_v2;
    logic [PROD_W-1:0]           r_prod [NUM_DIMS];
    t_walk_ctl                   r_ctl2;
    logic                        r_v3;
    logic [SRC_W-1:0]            r_src3;
    t_walk_ctl                   r_ctl3;
    logic                        out_free;
    logic                        s2_free;
    logic                        s1_free;
    logic [SRC_W-1:0]            sum;

    assign out_free = !r_v3 || i_m_ready;
    assign s2_free  = !r_v2 || out_free;
    assign s1_free  = !r_v1 || s2_free;
    assign o_ready  = s1_free;

    always_comb begin
        sum = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            sum = sum + SRC_W'(r_prod[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_idx1 <= i_idx;
            r_ctl1 <= i_ctl;
        end
        if (s2_free && r_v1) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_prod[d] <= PROD_W'(i_step[d*STEP_W +: STEP_W]) *
                             PROD_W'(r_idx1[d*IDX_W +: IDX_W]);
            end
            r_ctl2 <= r_ctl1;
        end
        if (out_free && r_v2) begin
            r_src3 <= sum;
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_valid = r_v3;
    assign o_src   = r_src3;
    assign o_ctl   = r_ctl3;

    `SWALK_ASSERT_NEXT(a_capture, i_valid && o_ready, r_v1)
    `SWALK_ASSERT_NEXT(a_out_hold, r_v3 && !i_m_ready, r_v3 && $stable(r_src3) && $stable(r_ctl3))
    `SWALK_ASSERT(a_empty_ready, !r_v1 |-> o_ready)
endmodule

// ----- rtl/core/strided_nd_address_walker.sv -----
// Top level of the strided N-dimensional address walker.
`timescale 1ns / 1ps
// Strided N-dimensional address walker. Each input beat steps a row-major
// odometer over NUM_DIMS dimensions (the last one fastest) and yields one
// result beat: the strided source offset, the sum over dimensions of stride
// times index, and the destination offset, which is the running element count.
// The beat of the final element carries tlast, and the walk then wraps to zero.
// Setting the restart bit of an input beat clears the index and count before
// that element is produced. A stride of zero repeats a dimension (broadcast).
// Throughput is one beat per clock cycle unless the master side stalls: the
// index state advances in the cycle a beat is accepted, and the offset
// arithmetic runs in a three-stage pipeline (index capture, stride multiplies,
// sum). A result beat is offered on the master side from the sum register.
// The slave side stalls only when all three stages hold results that the
// master side has not taken.
// Configuration registers are written through the cfg channel, which is always
// ready: indexes 0 to NUM_DIMS-1 are sizes (outermost first), the next NUM_DIMS
// are source strides; other indexes are ignored. Write them only while idle.
// A size of zero acts as one and a size above 256 acts as 256.
module strided_nd_address_walker #(
    parameter int NUM_DIMS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] restart, [7:1] zero
    input  logic [swalk_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [33:0] src_offset, [65:34] dst_offset, [71:66] zero
    output logic [swalk_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [$clog2(2*NUM_DIMS)-1:0]        i_cfg_index,
    input  logic [swalk_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import swalk_pkg::*;

    localparam int CFG_IDX_W = $clog2(2 * NUM_DIMS);

    logic [NUM_DIMS*SIZE_W-1:0] size_vec;
    logic [NUM_DIMS*STEP_W-1:0] step_vec;
    logic [NUM_DIMS*IDX_W-1:0]  idx_vec;
    t_walk_ctl                  walk_ctl;
    t_walk_ctl                  out_ctl;
    logic [SRC_W-1:0]           out_src;
    logic                       pipe_ready;
    logic                       accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = pipe_ready;
    assign accept        = s_axis_tvalid && pipe_ready;

    swalk_cfg #(
        .NUM_DIMS  (NUM_DIMS),
        .CFG_IDX_W (CFG_IDX_W)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_size  (size_vec),
        .o_step  (step_vec)
    );

    swalk_index #(
        .NUM_DIMS (NUM_DIMS)
    ) u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_restart (s_axis_tdata[0]),
        .i_size    (size_vec),
        .o_idx     (idx_vec),
        .o_ctl     (walk_ctl)
    );

    swalk_offset #(
        .NUM_DIMS (NUM_DIMS)
    ) u_offset (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (pipe_ready),
        .i_idx     (idx_vec),
        .i_ctl     (walk_ctl),
        .i_step    (step_vec),
        .o_valid   (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_src     (out_src),
        .o_ctl     (out_ctl)
    );

    assign m_axis_tdata = {(M_TDATA_W - SRC_W - DST_W)'(0), out_ctl.dst, out_src};
    assign m_axis_tlast = out_ctl.last;
endmodule
